// ===== src/olrs_pkg.sv =====
// Shared types and constants for the online linear regression block.
package olrs_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned LossW   = 31;
  localparam int unsigned CfgW    = 17;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned OpndW   = DataW + 1;
  localparam int unsigned ProdW   = 2 * OpndW;

  localparam logic [CfgW-1:0] CfgResetVal = CfgW'(7);

  localparam logic signed [DataW-1:0] S32Max = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] S32Min = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [LossW-1:0]        LossMax = {LossW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LRATE  = 1'b0,
    CFG_STEP_H = 1'b1
  } cfg_idx_e;

  // Datapath operations, one per controller step.
  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_LOAD = 4'd1,
    OP_MXW  = 4'd2,
    OP_PRED = 4'd3,
    OP_ERR  = 4'd4,
    OP_MXE  = 4'd5,
    OP_MXXH = 4'd6,
    OP_MEE  = 4'd7,
    OP_MLW  = 4'd8,
    OP_MLB  = 4'd9,
    OP_UPD  = 4'd10,
    OP_OUT  = 4'd11
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic train;
  } dp_status_t;

endpackage

// ===== src/olrs_if.sv =====
// Valid/ready channel interfaces for samples and results.
interface olrs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic signed [olrs_pkg::DataW-1:0]    x_value;
  logic signed [olrs_pkg::DataW-1:0]    label_value;

  modport source (output valid, command, x_value, label_value, input ready);
  modport sink   (input valid, command, x_value, label_value, output ready);
endinterface

interface olrs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [olrs_pkg::DataW-1:0]    prediction;
  logic        [olrs_pkg::LossW-1:0]    loss;
  logic signed [olrs_pkg::DataW-1:0]    new_weight;
  logic signed [olrs_pkg::DataW-1:0]    new_bias;

  modport source (output valid, prediction, loss, new_weight, new_bias, input ready);
  modport sink   (input valid, prediction, loss, new_weight, new_bias, output ready);
endinterface

// ===== src/olrs_ctrl.sv =====
// Sequencer that steps the shared-multiplier datapath through one sample.
module olrs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  olrs_pkg::dp_status_t status_i,
  output olrs_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_MXW  = 11'b000_0000_0010,
    S_PRED = 11'b000_0000_0100,
    S_ERR  = 11'b000_0000_1000,
    S_MXE  = 11'b000_0001_0000,
    S_MXXH = 11'b000_0010_0000,
    S_MEE  = 11'b000_0100_0000,
    S_MLW  = 11'b000_1000_0000,
    S_MLB  = 11'b001_0000_0000,
    S_UPD  = 11'b010_0000_0000,
    S_FIN  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   load_out;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign load_out    = (state_q == S_FIN) && slot_free;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = olrs_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = olrs_pkg::OP_LOAD;
          state_d  = S_MXW;
        end
      end
      S_MXW: begin
        cmd_o.op = olrs_pkg::OP_MXW;
        state_d  = S_PRED;
      end
      S_PRED: begin
        cmd_o.op = olrs_pkg::OP_PRED;
        state_d  = status_i.train ? S_ERR : S_FIN;
      end
      S_ERR: begin
        cmd_o.op = olrs_pkg::OP_ERR;
        state_d  = S_MXE;
      end
      S_MXE: begin
        cmd_o.op = olrs_pkg::OP_MXE;
        state_d  = S_MXXH;
      end
      S_MXXH: begin
        cmd_o.op = olrs_pkg::OP_MXXH;
        state_d  = S_MEE;
      end
      S_MEE: begin
        cmd_o.op = olrs_pkg::OP_MEE;
        state_d  = S_MLW;
      end
      S_MLW: begin
        cmd_o.op = olrs_pkg::OP_MLW;
        state_d  = S_MLB;
      end
      S_MLB: begin
        cmd_o.op = olrs_pkg::OP_MLB;
        state_d  = S_UPD;
      end
      S_UPD: begin
        cmd_o.op = olrs_pkg::OP_UPD;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.op = olrs_pkg::OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/olrs_dp.sv =====
// Datapath: one shared 33x33 multiplier, model state and config registers.
module olrs_dp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  olrs_pkg::dp_cmd_t                   cmd_i,
  output olrs_pkg::dp_status_t                status_o,
  input  logic                                cfg_we_i,
  input  logic [olrs_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [olrs_pkg::CfgW-1:0]           cfg_data_i,
  input  logic                                command_i,
  input  logic signed [olrs_pkg::DataW-1:0]   x_value_i,
  input  logic signed [olrs_pkg::DataW-1:0]   label_value_i,
  output logic signed [olrs_pkg::DataW-1:0]   prediction_o,
  output logic        [olrs_pkg::LossW-1:0]   loss_o,
  output logic signed [olrs_pkg::DataW-1:0]   new_weight_o,
  output logic signed [olrs_pkg::DataW-1:0]   new_bias_o
);

  localparam int unsigned DW = olrs_pkg::DataW;
  localparam int unsigned OW = olrs_pkg::OpndW;
  localparam int unsigned PW = olrs_pkg::ProdW;
  localparam int unsigned CW = olrs_pkg::CfgW;

  // floor(p / 2^FRAC_BITS), saturated to signed 32 bits
  function automatic logic signed [DW-1:0] fx_sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p >>> FRAC_BITS;
    if ((&s[PW-1:DW-1]) || !(|s[PW-1:DW-1])) begin
      return s[DW-1:0];
    end else begin
      return s[PW-1] ? olrs_pkg::S32Min : olrs_pkg::S32Max;
    end
  endfunction

  function automatic logic signed [DW-1:0] sat34(input logic signed [DW+1:0] v);
    if ((&v[DW+1:DW-1]) || !(|v[DW+1:DW-1])) begin
      return v[DW-1:0];
    end else begin
      return v[DW+1] ? olrs_pkg::S32Min : olrs_pkg::S32Max;
    end
  endfunction

  function automatic logic signed [DW+1:0] ext2(input logic signed [DW-1:0] v);
    return {{2{v[DW-1]}}, v};
  endfunction

  logic                 train_q;
  logic signed [DW-1:0] x_q, label_q;
  logic signed [DW-1:0] weight_q, bias_q;
  logic [CW-1:0]        lr_q, h_q;
  logic signed [PW-1:0] prod_q;
  logic signed [DW-1:0] pred_q, e_q, xx_q, xe_q, gw_q, gb_q;
  logic [olrs_pkg::LossW-1:0] loss_q;

  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_d;
  logic signed [DW-1:0] prod_fx;
  logic signed [DW-1:0] half_h;
  logic signed [PW-1:0] loss_s;

  assign status_o.train = train_q;

  // Operand select for the shared multiplier
  always_comb begin
    unique case (cmd_i.op)
      olrs_pkg::OP_MXW: begin
        mul_a = {x_q[DW-1], x_q};
        mul_b = {weight_q[DW-1], weight_q};
      end
      olrs_pkg::OP_MXE: begin
        mul_a = {x_q[DW-1], x_q};
        mul_b = {e_q[DW-1], e_q};
      end
      olrs_pkg::OP_MXXH: begin
        mul_a = {xx_q[DW-1], xx_q};
        mul_b = {{(OW-CW){1'b0}}, h_q};
      end
      olrs_pkg::OP_MEE: begin
        mul_a = {e_q[DW-1], e_q};
        mul_b = {e_q[DW-1], e_q};
      end
      olrs_pkg::OP_MLW: begin
        mul_a = {{(OW-CW){1'b0}}, lr_q};
        mul_b = {gw_q[DW-1], gw_q};
      end
      olrs_pkg::OP_MLB: begin
        mul_a = {{(OW-CW){1'b0}}, lr_q};
        mul_b = {gb_q[DW-1], gb_q};
      end
      default: begin
        // x*x is issued during the prediction step
        mul_a = {x_q[DW-1], x_q};
        mul_b = {x_q[DW-1], x_q};
      end
    endcase
  end

  assign prod_d  = mul_a * mul_b;
  assign prod_fx = fx_sat(prod_q);
  assign half_h  = {{(DW-CW+1){1'b0}}, h_q[CW-1:1]};
  assign loss_s  = prod_q >>> (FRAC_BITS + 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= '0;
      bias_q   <= '0;
      lr_q     <= olrs_pkg::CfgResetVal;
      h_q      <= olrs_pkg::CfgResetVal;
      train_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (olrs_pkg::cfg_idx_e'(cfg_idx_i))
          olrs_pkg::CFG_LRATE:  lr_q <= cfg_data_i;
          olrs_pkg::CFG_STEP_H: h_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == olrs_pkg::OP_LOAD) begin
        train_q <= command_i;
      end
      if (cmd_i.op == olrs_pkg::OP_MLB) begin
        weight_q <= sat34(ext2(weight_q) - ext2(prod_fx));
      end
      if (cmd_i.op == olrs_pkg::OP_UPD) begin
        bias_q <= sat34(ext2(bias_q) - ext2(prod_fx));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (cmd_i.op)
      olrs_pkg::OP_LOAD: begin
        x_q     <= x_value_i;
        label_q <= label_value_i;
        loss_q  <= '0;
      end
      olrs_pkg::OP_PRED: pred_q <= sat34(ext2(prod_fx) + ext2(bias_q));
      olrs_pkg::OP_ERR: begin
        e_q  <= sat34(ext2(label_q) - ext2(pred_q));
        xx_q <= prod_fx;
      end
      olrs_pkg::OP_MXXH: xe_q <= prod_fx;
      olrs_pkg::OP_MEE: begin
        gw_q <= sat34(ext2(prod_fx >>> 1) - ext2(xe_q));
        gb_q <= sat34(ext2(half_h) - ext2(e_q));
      end
      olrs_pkg::OP_MLW: begin
        // e*e is never negative
        loss_q <= (|loss_s[PW-1:olrs_pkg::LossW]) ? olrs_pkg::LossMax
                                                  : loss_s[olrs_pkg::LossW-1:0];
      end
      olrs_pkg::OP_OUT: begin
        prediction_o <= pred_q;
        loss_o       <= loss_q;
        new_weight_o <= weight_q;
        new_bias_o   <= bias_q;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/online_linear_regression_sgd.sv =====
// Top level: online one-variable linear regression trained by SGD.
//
// Usage: samples arrive on sample_i (command, x_value, label_value, Q16.16
// by default) and one result per sample leaves on result_o (prediction,
// loss, new_weight, new_bias). Both are valid/ready channels; a transfer
// happens on a rising edge with valid and ready high.
// cfg_we_i/cfg_idx_i/cfg_data_i write the step size (index 0) and step_h
// (index 1); write them only while no sample is in flight.
// Timing: one shared 33x33 multiplier does every product, one per cycle.
// A predict sample goes through the load, x*weight and prediction steps;
// a train sample needs seven multiplies in a chain (x*weight, x*x, x*error,
// x*x*h, error*error and the two step-size products), then the weight and
// bias updates. A new sample is taken only once the last result is written.
// Reset clears weight and bias to zero, sets both config registers to 7
// and empties the result register.
// Stall: the result register holds while result_o.ready is low; the next
// sample is still taken and computed, and waits to be written until the
// result register has been freed.
module online_linear_regression_sgd #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [olrs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [olrs_pkg::CfgW-1:0]     cfg_data_i,
  olrs_in_if.sink                       sample_i,
  olrs_out_if.source                    result_o
);

  olrs_pkg::dp_cmd_t    cmd;
  olrs_pkg::dp_status_t status;

  // Sequencer: handshakes and step order
  olrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: multiplier, model state, config and result register
  olrs_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .command_i     (sample_i.command),
    .x_value_i     (sample_i.x_value),
    .label_value_i (sample_i.label_value),
    .prediction_o  (result_o.prediction),
    .loss_o        (result_o.loss),
    .new_weight_o  (result_o.new_weight),
    .new_bias_o    (result_o.new_bias)
  );

  // A sample transfer leaves the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready) |=> !sample_i.ready)
    else $error("input ready while a sample is in flight");

  // The result register is written only when it is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == olrs_pkg::OP_OUT) |-> (!result_o.valid || result_o.ready))
    else $error("result register overwritten before transfer");

  // A result appears only after a write of the result register.
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(cmd.op == olrs_pkg::OP_OUT))
    else $error("result valid without a result write");

  // The load step happens only on a sample transfer.
  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == olrs_pkg::OP_LOAD) |-> (sample_i.valid && sample_i.ready))
    else $error("sample loaded without a transfer");

endmodule

// ===== dv/tb.sv =====
// Testbench for the online linear regression SGD block: predicts and checks every result.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DataW   = olrs_pkg::DataW;
  localparam int unsigned LossW   = olrs_pkg::LossW;
  localparam int unsigned CfgW    = olrs_pkg::CfgW;
  localparam int unsigned CfgIdxW = olrs_pkg::CfgIdxW;

  localparam logic signed [DataW-1:0] S32Max      = olrs_pkg::S32Max;
  localparam logic signed [DataW-1:0] S32Min      = olrs_pkg::S32Min;
  localparam logic        [LossW-1:0] LossMax     = olrs_pkg::LossMax;
  localparam logic        [CfgW-1:0]  CfgResetVal = olrs_pkg::CfgResetVal;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned CycleLimit = 500000;
  // Leave room beyond the train latency for a stray late result.
  localparam int unsigned TailCycles = 40;

  localparam logic signed [DataW-1:0] QOne = DataW'(32'sd65536);

  typedef struct {
    logic                    command;
    logic signed [DataW-1:0] x_value;
    logic signed [DataW-1:0] label_value;
  } sample_t;

  typedef struct {
    logic signed [DataW-1:0] prediction;
    logic        [LossW-1:0] loss;
    logic signed [DataW-1:0] new_weight;
    logic signed [DataW-1:0] new_bias;
  } result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  olrs_in_if  smp_if ();
  olrs_out_if res_if ();

  online_linear_regression_sgd #(
    .FRAC_BITS (FracBits)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (smp_if),
    .result_o   (res_if)
  );

  // Samples waiting to be driven and results waiting to be seen.
  sample_t pending_samples[$];
  result_t expected_results[$];

  int unsigned n_queued;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned cycle_cnt;
  bit          idle_en;

  // Predictor copy of the block state and its two registers.
  longint weight_q;
  longint bias_q;
  longint lrate_q;
  longint hstep_q;

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  function automatic longint qsat(longint v);
    if (v > longint'(S32Max)) return longint'(S32Max);
    if (v < longint'(S32Min)) return longint'(S32Min);
    return v;
  endfunction

  // Full product, floor shift by the fraction bits, clamp to 32 bits.
  function automatic longint qmul(longint a, longint b);
    return qsat((a * b) >>> FracBits);
  endfunction

  // One sample through the regression: result from the old parameters,
  // then the gradient step on a train command.
  function automatic result_t sgd_step(sample_t s);
    longint x, lbl, pred, err, xe, xx, xxh, gw, gb, half_sq;
    result_t r;
    x    = s.x_value;
    lbl  = s.label_value;
    pred = qsat(qmul(x, weight_q) + bias_q);
    r.prediction = pred[DataW-1:0];
    r.loss       = '0;
    if (s.command) begin
      err = qsat(lbl - pred);
      xe  = qmul(x, err);
      xx  = qmul(x, x);
      xxh = qmul(xx, hstep_q);
      gw  = qsat((xxh >>> 1) - xe);
      gb  = qsat((hstep_q >>> 1) - err);
      half_sq = ((err * err) >>> FracBits) >>> 1;
      r.loss  = (half_sq > longint'(LossMax)) ? LossMax : half_sq[LossW-1:0];
      weight_q = qsat(weight_q - qmul(lrate_q, gw));
      bias_q   = qsat(bias_q - qmul(lrate_q, gb));
    end
    r.new_weight = weight_q[DataW-1:0];
    r.new_bias   = bias_q[DataW-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample driver: inputs move on the falling edge, transfers are seen on
  // the rising edge. Random idle gaps are inserted while idle_en is set.
  // ---------------------------------------------------------------------------

  bit smp_taken;
  int unsigned smp_gap;

  always @(posedge clk_i) begin
    if (rst_ni && smp_if.valid && smp_if.ready) begin
      sample_t s;
      s.command     = smp_if.command;
      s.x_value     = smp_if.x_value;
      s.label_value = smp_if.label_value;
      expected_results.push_back(sgd_step(s));
      smp_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!smp_if.valid || smp_taken)) begin
      smp_taken = 1'b0;
      if (smp_gap > 0) begin
        smp_gap--;
        smp_if.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        if (idle_en && $urandom_range(0, 9) == 0) begin
          // this cycle counts as the first of the gap
          smp_gap = $urandom_range(0, 11);
          smp_if.valid <= 1'b0;
        end else begin
          sample_t s;
          s = pending_samples.pop_front();
          smp_if.command     <= s.command;
          smp_if.x_value     <= s.x_value;
          smp_if.label_value <= s.label_value;
          smp_if.valid       <= 1'b1;
        end
      end else begin
        smp_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls on ready, independent of valid, so that
  // backpressure lands on every phase of the multiply chain.
  // ---------------------------------------------------------------------------

  int unsigned res_gap;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_gap > 0) begin
        res_gap--;
        res_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        res_gap = $urandom_range(0, 11);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(string fname, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transfer: expected none, actual pred %0d", $time,
                 res_if.prediction);
        n_errors++;
      end else begin
        result_t e;
        e = expected_results.pop_front();
        check_field("prediction", e.prediction, res_if.prediction);
        check_field("loss", e.loss, res_if.loss);
        check_field("new_weight", e.new_weight, res_if.new_weight);
        check_field("new_bias", e.new_bias, res_if.new_bias);
        n_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_sample(logic cmd, logic signed [DataW-1:0] x,
                             logic signed [DataW-1:0] lbl);
    sample_t s;
    s.command     = cmd;
    s.x_value     = x;
    s.label_value = lbl;
    pending_samples.push_back(s);
    n_queued++;
  endtask

  // Register writes only happen with nothing in flight; the predictor
  // copy follows the write.
  task automatic write_reg(olrs_pkg::cfg_idx_e idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == olrs_pkg::CFG_LRATE) lrate_q = val;
    else hstep_q = val;
  endtask

  task automatic drain();
    wait (n_checked == n_queued);
  endtask

  function automatic logic signed [DataW-1:0] corner_value();
    case ($urandom_range(0, 5))
      0:       return S32Max;
      1:       return S32Min;
      2:       return '0;
      3:       return DataW'(1);
      4:       return '1;
      default: return QOne;
    endcase
  endfunction

  // Mostly samples from a noisy line y = slope*x + icpt with x within
  // +/-8.0 so that training actually tracks; the rest is full-range noise
  // and corner values to hit every saturation path.
  task automatic run_random(int unsigned count, longint slope, longint icpt);
    int unsigned kind;
    longint xs, ys;
    logic cmd;
    for (int unsigned i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      cmd  = ($urandom_range(0, 3) != 0);
      if (kind < 60) begin
        xs = longint'($urandom_range(0, 1048576)) - 524288;
        ys = qsat(((slope * xs) >>> FracBits) + icpt
                  + longint'($urandom_range(0, 65536)) - 32768);
        push_sample(cmd, xs[DataW-1:0], ys[DataW-1:0]);
      end else if (kind < 85) begin
        push_sample(cmd, $urandom, $urandom);
      end else if (kind < 93) begin
        push_sample(cmd, corner_value(), corner_value());
      end else begin
        push_sample(cmd, corner_value(), $urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = olrs_pkg::CFG_LRATE;
    cfg_data_i   = '0;
    smp_if.valid       = 1'b0;
    smp_if.command     = 1'b0;
    smp_if.x_value     = '0;
    smp_if.label_value = '0;
    res_if.ready = 1'b0;
    smp_taken = 1'b0;
    smp_gap   = 0;
    res_gap   = 0;
    n_queued  = 0;
    n_checked = 0;
    n_errors  = 0;
    cycle_cnt = 0;
    idle_en   = 1'b1;
    weight_q  = 0;
    bias_q    = 0;
    lrate_q   = CfgResetVal;
    hstep_q   = CfgResetVal;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset register values: predict ignores its label, train
    // with extreme features and labels.
    push_sample(1'b0, S32Max, S32Min);
    push_sample(1'b1, QOne, DataW'(32'sd196608));
    push_sample(1'b1, S32Max, S32Max);
    push_sample(1'b1, S32Min, S32Min);
    push_sample(1'b0, S32Min, S32Max);
    push_sample(1'b1, '0, S32Min);
    push_sample(1'b1, '1, S32Max);
    drain();

    // Unit step size, zero difference step: loss saturation and large swings.
    write_reg(olrs_pkg::CFG_LRATE, CfgW'(65536));
    write_reg(olrs_pkg::CFG_STEP_H, '0);
    push_sample(1'b1, DataW'(32'sd131072), S32Max);
    push_sample(1'b0, S32Max, '0);
    push_sample(1'b1, S32Min, S32Max);
    push_sample(1'b0, -QOne, '1);
    drain();

    // All-ones registers, beyond the nominal range.
    write_reg(olrs_pkg::CFG_LRATE, '1);
    write_reg(olrs_pkg::CFG_STEP_H, '1);
    push_sample(1'b1, S32Max, S32Min);
    push_sample(1'b1, QOne, '0);
    push_sample(1'b0, DataW'(1), S32Max);
    push_sample(1'b1, DataW'(-2), DataW'(1));
    drain();

    // Random phases across register settings; state carries over.
    write_reg(olrs_pkg::CFG_LRATE, CfgW'(7));
    write_reg(olrs_pkg::CFG_STEP_H, CfgW'(7));
    run_random(300, 3 * 65536, -65536);
    drain();

    write_reg(olrs_pkg::CFG_LRATE, CfgW'(655));
    run_random(400, -2 * 65536, 5 * 65536);
    drain();

    write_reg(olrs_pkg::CFG_LRATE, '0);
    write_reg(olrs_pkg::CFG_STEP_H, '1);
    run_random(200, 65536, 0);
    drain();

    write_reg(olrs_pkg::CFG_LRATE, CfgW'(65536));
    write_reg(olrs_pkg::CFG_STEP_H, '0);
    run_random(200, 32768, 65536);
    drain();

    write_reg(olrs_pkg::CFG_LRATE, '1);
    write_reg(olrs_pkg::CFG_STEP_H, CfgW'(1));
    run_random(200, -65536, -3 * 65536);
    drain();

    write_reg(olrs_pkg::CFG_LRATE, CfgW'(3277));
    write_reg(olrs_pkg::CFG_STEP_H, CfgW'(65536));
    run_random(300, 2 * 65536, 0);
    drain();

    // Last stretch at full rate on both sides.
    idle_en = 1'b0;
    write_reg(olrs_pkg::CFG_LRATE, CfgW'(66));
    write_reg(olrs_pkg::CFG_STEP_H, CfgW'(7));
    run_random(300, 65536, 2 * 65536);
    drain();

    repeat (TailCycles) @(posedge clk_i);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
